// ===== rtl/vsd_pkg.sv =====
// vsd_pkg: shared types and constants of the prefix varint stream decoder
// used by vsd_front, vsd_queue, vsd_back and varint_stream_decoder
`timescale 1ns / 1ps

package vsd_pkg;

  // header class boundaries
  localparam logic [7:0] HdrCut1 = 8'd178;
  localparam logic [7:0] HdrCut2 = 8'd242;
  localparam logic [7:0] HdrCut3 = 8'd250;
  // header 250 carries three payload bytes, so the count is header - 247
  localparam logic [7:0] LongLenBias = 8'd247;

  localparam logic [63:0] OffsetOne = 64'd178;
  localparam logic [63:0] OffsetTwo = OffsetOne + (64'd1 << 14);

  localparam int unsigned CountW = 16;

  // one classified stream byte, handed from front to back
  typedef struct packed {
    logic        load;    // start a new value: accumulator takes addend
    logic        emit;    // this byte completes a value
    logic [63:0] addend;
  } op_t;

endpackage

// ===== rtl/varint_stream_decoder.sv =====
// varint_stream_decoder: one stream byte per beat in, one 64-bit value per
// completed varint out; the completing byte passes the op queue and the
// back-end result register. Throughput: one byte per cycle unless stalled,
// set by the op queue and the single 64-bit add in the back end. Reset:
// decode state and queue clear, value_count reads 1.
`timescale 1ns / 1ps

module varint_stream_decoder import vsd_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        code_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [63:0]       value_o,
  output logic              last_value_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CountW-1:0] cfg_data_i
);

  logic push, full, pop, op_valid;
  op_t  front_op, back_op;

  assign cfg_ready_o = 1'b1;

  vsd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .code_byte_i (code_byte_i),
    .in_stall_o  (in_stall_o),
    .full_i      (full),
    .push_o      (push),
    .op_o        (front_op)
  );

  vsd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_op),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (op_valid),
    .data_o  (back_op)
  );

  vsd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .op_valid_i   (op_valid),
    .op_i         (back_op),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .value_o      (value_o),
    .last_value_o (last_value_o)
  );

endmodule

// ===== rtl/vsd_front.sv =====
// vsd_front: accepts stream bytes, tracks header and payload position,
// turns each byte into an op_t for the back end; depends on vsd_pkg
`timescale 1ns / 1ps

module vsd_front import vsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] code_byte_i,
  output logic       in_stall_o,
  input  logic       full_i,
  output logic       push_o,
  output op_t        op_o
);

  logic [3:0] bytes_left_q, bytes_left_d;
  logic [2:0] byte_pos_q, byte_pos_d;
  logic       accept;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;

  always_comb begin
    op_o         = '0;
    bytes_left_d = bytes_left_q;
    byte_pos_d   = byte_pos_q;
    if (bytes_left_q == 4'd0) begin
      byte_pos_d = 3'd0;
      op_o.load  = 1'b1;
      if (code_byte_i < HdrCut1) begin
        op_o.emit   = 1'b1;
        op_o.addend = 64'(code_byte_i);
      end else if (code_byte_i < HdrCut2) begin
        op_o.addend  = OffsetOne + (64'(code_byte_i - HdrCut1) << 8);
        bytes_left_d = 4'd1;
      end else if (code_byte_i < HdrCut3) begin
        op_o.addend  = OffsetTwo + (64'(code_byte_i - HdrCut2) << 16);
        bytes_left_d = 4'd2;
      end else begin
        op_o.addend  = 64'd0;
        bytes_left_d = 4'(code_byte_i - LongLenBias);
      end
    end else begin
      // payload beat, little-endian
      op_o.addend  = 64'(code_byte_i) << {byte_pos_q, 3'b000};
      op_o.emit    = (bytes_left_q == 4'd1);
      bytes_left_d = bytes_left_q - 4'd1;
      byte_pos_d   = byte_pos_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= 4'd0;
      byte_pos_q   <= 3'd0;
    end else if (accept) begin
      bytes_left_q <= bytes_left_d;
      byte_pos_q   <= byte_pos_d;
    end
  end

  a_left_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bytes_left_q <= 4'd8)
    else $error("payload count above eight");

  a_long_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && bytes_left_q == 4'd0 && code_byte_i >= HdrCut3)
    |=> (bytes_left_q >= 4'd3))
    else $error("long header gave too few payload bytes");

endmodule

// ===== rtl/vsd_queue.sv =====
// vsd_queue: short fifo of op_t between front and back
// depends on vsd_pkg
`timescale 1ns / 1ps

module vsd_queue import vsd_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output op_t  data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  op_t             mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    if (p == PtrW'(Depth - 1)) return '0;
    return p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (do_push && !do_pop)      count_q <= count_q + CntW'(1);
      else if (do_pop && !do_push) count_q <= count_q - CntW'(1);
    end
  end

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count above depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

endmodule

// ===== rtl/vsd_back.sv =====
// vsd_back: accumulates ops into values, keeps the batch counter and the
// result register; depends on vsd_pkg
`timescale 1ns / 1ps

module vsd_back import vsd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [CountW-1:0] cfg_data_i,
  input  logic              op_valid_i,
  input  op_t               op_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [63:0]       value_o,
  output logic              last_value_o
);

  logic [63:0]       acc_q, acc_d;
  logic [CountW-1:0] value_count_q;
  logic [CountW-1:0] values_left_q, values_left_d;
  logic              out_valid_q, out_valid_d;
  logic [63:0]       value_q;
  logic              last_q;
  logic              slot_free, fire;

  // an emitting op needs the result register, others always drain
  assign slot_free = !out_valid_q || !out_stall_i;
  assign pop_o     = op_valid_i && (!op_i.emit || slot_free);
  assign fire      = pop_o && op_i.emit;

  assign acc_d = op_i.load ? op_i.addend : (acc_q + op_i.addend);

  always_comb begin
    values_left_d = values_left_q;
    if (cfg_valid_i) begin
      values_left_d = cfg_data_i;
    end else if (fire) begin
      values_left_d = (values_left_q <= CountW'(1)) ? value_count_q
                                                    : values_left_q - CountW'(1);
    end
    out_valid_d = out_valid_q;
    if (fire)              out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_count_q <= CountW'(1);
      values_left_q <= CountW'(1);
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) value_count_q <= cfg_data_i;
      values_left_q <= values_left_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) acc_q <= acc_d;
    if (fire) begin
      value_q <= acc_d;
      last_q  <= (values_left_q <= CountW'(1));
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = value_q;
  assign last_value_o = last_q;

  a_batch_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && values_left_q <= CountW'(1)) |=> (values_left_q == value_count_q))
    else $error("batch counter not reloaded after last value");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && out_valid_q) |-> !out_stall_i)
    else $error("pending result overwritten");

endmodule
